// ===== rtl/gst_pkg.sv =====
// Shared types and constants for the generational slot table.
// Used by gst_ctrl, gst_datapath and generational_slot_table; depends on nothing.
package gst_pkg;

    localparam int SLOTS        = 256;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PAYLOAD_BITS = 64;
    localparam int CNT_W        = 9;
    localparam int MODE_W       = 3;
    localparam int INDEX_W      = 16;
    localparam int GEN_W        = 32;
    localparam int PAY_PORT_W   = 64;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    localparam logic [MODE_W-1:0] MODE_ACTIVATE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IDENTITY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PUBLISH  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_ISSUE    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic ok;
        logic wr_gen;
        logic clr_live;
        logic inc_live;
        logic dec_live;
        logic wr_pay;
        logic inc_pub;
        logic dec_pub;
        logic show_id;
        logic show_pay;
        logic show_issue;
        logic step_gen;
        logic clear_all;
        logic wipe;
    } t_cmd;

    // Status of the captured transaction and its slot, back to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              gen_nz;
        logic              in_range;
        logic              live;
        logic              gen_eq;
        logic              pub;
        logic              act;
        logic              wipe_last;
    } t_status;

endpackage

// ===== rtl/gst_ctrl.sv =====
// Controller of the generational slot table: a small sequencer that turns
// slot status into update commands and runs the clearing pass. Depends on gst_pkg.
module gst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  gst_pkg::t_status i_status,
    output gst_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WIPE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_held;

    // Reset enters the clearing pass so that every slot starts free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WIPE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = start ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = (i_status.mode == gst_pkg::MODE_CLEAR) ? ST_WIPE : ST_IDLE;
            ST_WIPE: n_state = i_status.wipe_last ? ST_IDLE : ST_WIPE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    // A handle is held when it is valid, in range and its slot carries exactly that generation.
    assign w_held = i_status.gen_nz && i_status.in_range && i_status.live && i_status.gen_eq;

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == ST_IDLE) && start;
        o_cmd.wipe    = (r_state == ST_WIPE);
        if (r_state == ST_EXEC) begin
            o_cmd.execute = 1'b1;
            unique case (i_status.mode)
                gst_pkg::MODE_ACTIVATE: begin
                    o_cmd.ok       = i_status.gen_nz && i_status.in_range;
                    o_cmd.wr_gen   = o_cmd.ok;
                    o_cmd.inc_live = o_cmd.ok && !i_status.live;
                    o_cmd.dec_pub  = o_cmd.ok && i_status.live && !i_status.gen_eq
                                     && i_status.pub;
                end
                gst_pkg::MODE_RELEASE: begin
                    o_cmd.ok       = w_held;
                    o_cmd.clr_live = w_held;
                    o_cmd.dec_live = w_held;
                    o_cmd.dec_pub  = w_held && i_status.pub;
                end
                gst_pkg::MODE_CONTAINS: begin
                    o_cmd.ok = w_held;
                end
                gst_pkg::MODE_IDENTITY: begin
                    o_cmd.ok      = i_status.in_range && i_status.live;
                    o_cmd.show_id = o_cmd.ok;
                end
                gst_pkg::MODE_PUBLISH: begin
                    o_cmd.ok      = w_held && i_status.act;
                    o_cmd.wr_pay  = o_cmd.ok;
                    o_cmd.inc_pub = o_cmd.ok && !i_status.pub;
                end
                gst_pkg::MODE_QUERY: begin
                    o_cmd.ok       = w_held && i_status.pub;
                    o_cmd.show_pay = o_cmd.ok;
                end
                gst_pkg::MODE_ISSUE: begin
                    o_cmd.ok         = 1'b1;
                    o_cmd.show_issue = 1'b1;
                    o_cmd.step_gen   = 1'b1;
                end
                gst_pkg::MODE_CLEAR: begin
                    o_cmd.ok        = 1'b1;
                    o_cmd.clear_all = 1'b1;
                end
                default: o_cmd.ok = 1'b0;
            endcase
        end
    end

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_state != ST_EXEC))
        else $error("execution lasted more than one cycle");

    a_live_inc_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.inc_live && o_cmd.dec_live))
        else $error("live count raised and lowered together");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_gen || o_cmd.wr_pay) |-> i_status.in_range)
        else $error("slot written outside the table");

    a_capture_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> !busy)
        else $error("transaction captured while busy");

endmodule

// ===== rtl/gst_datapath.sv =====
// Datapath of the generational slot table: generation, published-flag and payload
// memories, the clearing address, counters and the result registers. Depends on gst_pkg.
module gst_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  gst_pkg::t_cmd                        i_cmd,
    input  logic [gst_pkg::MODE_W-1:0]           i_mode,
    input  logic [gst_pkg::INDEX_W-1:0]          i_slot_index,
    input  logic [gst_pkg::GEN_W-1:0]            i_generation,
    input  logic                                 i_publish_active,
    input  logic [gst_pkg::PAY_PORT_W-1:0]       i_payload_in,
    output gst_pkg::t_status                     o_status,
    output logic                                 o_valid,
    output logic                                 o_ok,
    output logic [gst_pkg::INDEX_W-1:0]          o_out_slot,
    output logic [gst_pkg::GEN_W-1:0]            o_out_generation,
    output logic [gst_pkg::PAY_PORT_W-1:0]       o_payload_out,
    output logic [gst_pkg::CNT_W-1:0]           o_live_count,
    output logic [gst_pkg::CNT_W-1:0]           o_published_count
);

    logic [gst_pkg::GEN_W-1:0]        r_gen_mem [gst_pkg::SLOTS];
    logic                             r_pub_mem [gst_pkg::SLOTS];
    logic [gst_pkg::PAYLOAD_BITS-1:0] r_pay_mem [gst_pkg::SLOTS];

    logic [gst_pkg::MODE_W-1:0]       r_mode;
    logic [gst_pkg::INDEX_W-1:0]      r_slot;
    logic [gst_pkg::GEN_W-1:0]        r_gen;
    logic                             r_act;
    logic [gst_pkg::PAYLOAD_BITS-1:0] r_pay_in;
    logic [gst_pkg::GEN_W-1:0]        r_gen_rd;
    logic                             r_pub_rd;
    logic [gst_pkg::PAYLOAD_BITS-1:0] r_pay_rd;
    logic [gst_pkg::SLOT_W-1:0]       r_wipe_addr;
    logic [gst_pkg::CNT_W-1:0]        r_live_cnt;
    logic [gst_pkg::CNT_W-1:0]        r_pub_cnt;
    logic [gst_pkg::CNT_W-1:0]        n_live_cnt;
    logic [gst_pkg::CNT_W-1:0]        n_pub_cnt;
    logic [gst_pkg::GEN_W-1:0]        r_next_gen;
    logic                             r_valid;
    logic                             r_ok;
    logic [gst_pkg::INDEX_W-1:0]      r_out_slot;
    logic [gst_pkg::GEN_W-1:0]        r_out_gen;
    logic [gst_pkg::PAY_PORT_W-1:0]   r_out_pay;

    logic [gst_pkg::SLOT_W-1:0]       w_in_addr;
    logic [gst_pkg::SLOT_W-1:0]       w_addr;
    logic [gst_pkg::SLOT_W-1:0]       w_wr_addr;
    logic                             w_gen_we;
    logic [gst_pkg::GEN_W-1:0]        w_gen_wdata;
    logic                             w_pub_we;

    assign w_in_addr = i_slot_index[gst_pkg::SLOT_W-1:0];
    assign w_addr    = r_slot[gst_pkg::SLOT_W-1:0];

    // Input capture; the memories are read at the accepting edge so that the
    // data is ready in the execute cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode   <= i_mode;
            r_slot   <= i_slot_index;
            r_gen    <= i_generation;
            r_act    <= i_publish_active;
            r_pay_in <= i_payload_in[gst_pkg::PAYLOAD_BITS-1:0];
            r_gen_rd <= r_gen_mem[w_in_addr];
            r_pub_rd <= r_pub_mem[w_in_addr];
            r_pay_rd <= r_pay_mem[w_in_addr];
        end
    end

    // The clearing pass and the execute cycle share one write port.
    assign w_wr_addr   = i_cmd.wipe ? r_wipe_addr : w_addr;
    assign w_gen_we    = i_cmd.wipe || i_cmd.wr_gen || i_cmd.clr_live;
    assign w_gen_wdata = i_cmd.wr_gen ? r_gen : '0;
    assign w_pub_we    = i_cmd.wipe || i_cmd.wr_pay || i_cmd.dec_pub;

    always_ff @(posedge i_clk) begin
        if (w_gen_we) begin
            r_gen_mem[w_wr_addr] <= w_gen_wdata;
        end
        if (w_pub_we) begin
            r_pub_mem[w_wr_addr] <= i_cmd.wr_pay;
        end
        if (i_cmd.wr_pay) begin
            r_pay_mem[w_addr] <= r_pay_in;
        end
    end

    // The clearing address always comes back to zero at the end of a pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wipe_addr <= '0;
        end else if (i_cmd.wipe) begin
            if (r_wipe_addr == gst_pkg::SLOT_LAST) begin
                r_wipe_addr <= '0;
            end else begin
                r_wipe_addr <= r_wipe_addr + 1'b1;
            end
        end
    end

    // A generation of zero marks a free slot.
    assign o_status.mode      = r_mode;
    assign o_status.gen_nz    = (r_gen != '0);
    assign o_status.in_range  = (32'(r_slot) < 32'(gst_pkg::SLOTS));
    assign o_status.live      = (r_gen_rd != '0);
    assign o_status.gen_eq    = (r_gen_rd == r_gen);
    assign o_status.pub       = r_pub_rd;
    assign o_status.act       = r_act;
    assign o_status.wipe_last = (r_wipe_addr == gst_pkg::SLOT_LAST);

    always_comb begin
        n_live_cnt = r_live_cnt;
        n_pub_cnt  = r_pub_cnt;
        if (i_cmd.inc_live) n_live_cnt = r_live_cnt + 1'b1;
        if (i_cmd.dec_live) n_live_cnt = r_live_cnt - 1'b1;
        if (i_cmd.inc_pub)  n_pub_cnt  = r_pub_cnt + 1'b1;
        if (i_cmd.dec_pub)  n_pub_cnt  = r_pub_cnt - 1'b1;
        if (i_cmd.clear_all) begin
            n_live_cnt = '0;
            n_pub_cnt  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_cnt <= '0;
            r_pub_cnt  <= '0;
            r_next_gen <= 32'd1;
            r_valid    <= 1'b0;
        end else begin
            r_valid    <= i_cmd.execute;
            r_live_cnt <= n_live_cnt;
            r_pub_cnt  <= n_pub_cnt;
            if (i_cmd.step_gen) begin
                r_next_gen <= r_next_gen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_ok       <= i_cmd.ok;
            r_out_slot <= i_cmd.show_id ? r_slot : '0;
            if (i_cmd.show_id) begin
                r_out_gen <= r_gen_rd;
            end else if (i_cmd.show_issue) begin
                r_out_gen <= r_next_gen;
            end else begin
                r_out_gen <= '0;
            end
            r_out_pay <= i_cmd.show_pay ? gst_pkg::PAY_PORT_W'(r_pay_rd) : '0;
        end
    end

    assign o_valid           = r_valid;
    assign o_ok              = r_ok;
    assign o_out_slot        = r_out_slot;
    assign o_out_generation  = r_out_gen;
    assign o_payload_out     = r_out_pay;
    assign o_live_count      = r_live_cnt;
    assign o_published_count = r_pub_cnt;

    a_live_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live_cnt <= gst_pkg::CNT_W'(gst_pkg::SLOTS))
        else $error("live count beyond the table size");

    a_pub_within_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pub_cnt <= r_live_cnt)
        else $error("more published slots than live slots");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for more than one cycle");

    a_wipe_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wipe |-> !(i_cmd.wr_gen || i_cmd.wr_pay || i_cmd.clr_live || i_cmd.dec_pub))
        else $error("slot update during the clearing pass");

endmodule

// ===== rtl/generational_slot_table.sv =====
// Top level of the generational slot table: joins the controller and datapath.
// Depends on gst_pkg, gst_ctrl and gst_datapath.
//
// Usage: drive the transaction fields and raise start; the transaction is
// taken at the rising edge where start is high and busy is low. Every
// transaction gives exactly one result, shown for one cycle with o_valid high;
// o_live_count and o_published_count give the counts after it.
// The result is registered: o_valid is high in the cycle after the execute cycle.
// The slot's generation, published flag and payload are read from memory at the
// accepting edge and written back in the execute cycle, during which busy is high;
// a new transaction is taken only once this read-modify-write is done. Clear gives
// its result in the same way but then walks every slot, one per cycle, so busy
// stays high until the last slot is cleared. The receiver cannot stall, so a
// result is never held back.
// Synchronous reset zeroes both counts and sets the generation counter to one;
// busy is high during reset and after it while the same clearing pass frees
// every slot.
module generational_slot_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gst_pkg::MODE_W-1:0]          i_mode,
    input  logic [gst_pkg::INDEX_W-1:0]         i_slot_index,
    input  logic [gst_pkg::GEN_W-1:0]           i_generation,
    input  logic                                i_publish_active,
    input  logic [gst_pkg::PAY_PORT_W-1:0]      i_payload_in,
    output logic                                o_valid,
    output logic                                o_ok,
    output logic [gst_pkg::INDEX_W-1:0]         o_out_slot,
    output logic [gst_pkg::GEN_W-1:0]           o_out_generation,
    output logic [gst_pkg::PAY_PORT_W-1:0]      o_payload_out,
    output logic [gst_pkg::CNT_W-1:0]           o_live_count,
    output logic [gst_pkg::CNT_W-1:0]           o_published_count
);

    gst_pkg::t_cmd    w_cmd;
    gst_pkg::t_status w_status;

    gst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    gst_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_mode            (i_mode),
        .i_slot_index      (i_slot_index),
        .i_generation      (i_generation),
        .i_publish_active  (i_publish_active),
        .i_payload_in      (i_payload_in),
        .o_status          (w_status),
        .o_valid           (o_valid),
        .o_ok              (o_ok),
        .o_out_slot        (o_out_slot),
        .o_out_generation  (o_out_generation),
        .o_payload_out     (o_payload_out),
        .o_live_count      (o_live_count),
        .o_published_count (o_published_count)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for generational_slot_table: directed and random transactions,
// with a scoreboard class that predicts every result and compares it on arrival.
// Depends on gst_pkg and the generational_slot_table RTL.
module testbench;

    typedef struct packed {
        logic                           ok;
        logic [gst_pkg::INDEX_W-1:0]    slot;
        logic [gst_pkg::GEN_W-1:0]      gen;
        logic [gst_pkg::PAY_PORT_W-1:0] pay;
        logic [gst_pkg::CNT_W-1:0]      live;
        logic [gst_pkg::CNT_W-1:0]      pub;
    } t_table_result;

    class slot_table_checker;
        logic [gst_pkg::GEN_W-1:0]      gen_of [gst_pkg::SLOTS];
        bit                             has_pay [gst_pkg::SLOTS];
        logic [gst_pkg::PAY_PORT_W-1:0] pay_of [gst_pkg::SLOTS];
        logic [gst_pkg::CNT_W-1:0]      live_n;
        logic [gst_pkg::CNT_W-1:0]      pub_n;
        logic [gst_pkg::GEN_W-1:0]      next_gen;
        t_table_result                  pending_results[$];
        int                             errors;

        function new();
            foreach (gen_of[k]) begin
                gen_of[k]  = '0;
                has_pay[k] = 1'b0;
                pay_of[k]  = '0;
            end
            live_n   = '0;
            pub_n    = '0;
            next_gen = gst_pkg::GEN_W'(1);
            errors   = 0;
        endfunction

        function void drop_payload(int idx);
            if (has_pay[idx]) begin
                has_pay[idx] = 1'b0;
                pub_n--;
            end
        endfunction

        // Work out the result of one accepted transaction and update the table copy.
        function void note_command(logic [gst_pkg::MODE_W-1:0] mode,
                                   logic [gst_pkg::INDEX_W-1:0] slot,
                                   logic [gst_pkg::GEN_W-1:0] gen, logic act,
                                   logic [gst_pkg::PAY_PORT_W-1:0] pay);
            t_table_result r;
            logic          in_range;
            logic          held;
            int            idx;
            r        = '0;
            idx      = int'(slot[gst_pkg::SLOT_W-1:0]);
            in_range = (int'(slot) < gst_pkg::SLOTS);
            held     = (gen != 0) && in_range && (gen_of[idx] == gen);
            case (mode)
                gst_pkg::MODE_ACTIVATE: begin
                    if (gen != 0 && in_range) begin
                        if (gen_of[idx] == 0)
                            live_n++;
                        else if (gen_of[idx] != gen)
                            drop_payload(idx);
                        gen_of[idx] = gen;
                        r.ok = 1'b1;
                    end
                end
                gst_pkg::MODE_RELEASE: begin
                    if (held) begin
                        gen_of[idx] = '0;
                        drop_payload(idx);
                        live_n--;
                        r.ok = 1'b1;
                    end
                end
                gst_pkg::MODE_CONTAINS: r.ok = held;
                gst_pkg::MODE_IDENTITY: begin
                    if (in_range && gen_of[idx] != 0) begin
                        r.ok   = 1'b1;
                        r.slot = slot;
                        r.gen  = gen_of[idx];
                    end
                end
                gst_pkg::MODE_PUBLISH: begin
                    if (held && act) begin
                        if (!has_pay[idx])
                            pub_n++;
                        has_pay[idx] = 1'b1;
                        pay_of[idx]  = pay;
                        r.ok = 1'b1;
                    end
                end
                gst_pkg::MODE_QUERY: begin
                    if (held && has_pay[idx]) begin
                        r.ok  = 1'b1;
                        r.pay = pay_of[idx];
                    end
                end
                gst_pkg::MODE_ISSUE: begin
                    r.gen    = next_gen;
                    next_gen = next_gen + 1'b1;
                    r.ok     = 1'b1;
                end
                default: begin
                    foreach (gen_of[k]) begin
                        gen_of[k]  = '0;
                        has_pay[k] = 1'b0;
                    end
                    live_n = '0;
                    pub_n  = '0;
                    r.ok   = 1'b1;
                end
            endcase
            r.live = live_n;
            r.pub  = pub_n;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic ok, logic [gst_pkg::INDEX_W-1:0] slot,
                                   logic [gst_pkg::GEN_W-1:0] gen,
                                   logic [gst_pkg::PAY_PORT_W-1:0] pay,
                                   logic [gst_pkg::CNT_W-1:0] live,
                                   logic [gst_pkg::CNT_W-1:0] pub);
            t_table_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no transaction outstanding, expected none, actual %h",
                         $time, {ok, slot, gen, pay, live, pub});
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("ok", 64'(want.ok), 64'(ok));
            compare_field("out_slot", 64'(want.slot), 64'(slot));
            compare_field("out_generation", 64'(want.gen), 64'(gen));
            compare_field("payload_out", want.pay, pay);
            compare_field("live_count", 64'(want.live), 64'(live));
            compare_field("published_count", 64'(want.pub), 64'(pub));
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [gst_pkg::MODE_W-1:0]     i_mode;
    logic [gst_pkg::INDEX_W-1:0]    i_slot_index;
    logic [gst_pkg::GEN_W-1:0]      i_generation;
    logic                           i_publish_active;
    logic [gst_pkg::PAY_PORT_W-1:0] i_payload_in;
    logic                           o_valid;
    logic                           o_ok;
    logic [gst_pkg::INDEX_W-1:0]    o_out_slot;
    logic [gst_pkg::GEN_W-1:0]      o_out_generation;
    logic [gst_pkg::PAY_PORT_W-1:0] o_payload_out;
    logic [gst_pkg::CNT_W-1:0]      o_live_count;
    logic [gst_pkg::CNT_W-1:0]      o_published_count;

    slot_table_checker sb = new();

    generational_slot_table dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_slot_index      (i_slot_index),
        .i_generation      (i_generation),
        .i_publish_active  (i_publish_active),
        .i_payload_in      (i_payload_in),
        .o_valid           (o_valid),
        .o_ok              (o_ok),
        .o_out_slot        (o_out_slot),
        .o_out_generation  (o_out_generation),
        .o_payload_out     (o_payload_out),
        .o_live_count      (o_live_count),
        .o_published_count (o_published_count)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_ok, o_out_slot, o_out_generation, o_payload_out,
                            o_live_count, o_published_count);
    end

    // Idle for the given number of cycles, then offer one transaction until it is taken.
    task automatic issue_command(input logic [gst_pkg::MODE_W-1:0] mode,
                                 input logic [gst_pkg::INDEX_W-1:0] slot,
                                 input logic [gst_pkg::GEN_W-1:0] gen, input logic act,
                                 input logic [gst_pkg::PAY_PORT_W-1:0] pay, input int gap);
        int n;
        for (n = 0; n < gap; n++) begin
            @(negedge i_clk);
            start            <= 1'b0;
            i_mode           <= gst_pkg::MODE_W'($urandom);
            i_slot_index     <= gst_pkg::INDEX_W'($urandom);
            i_generation     <= $urandom;
            i_publish_active <= 1'($urandom);
            i_payload_in     <= {$urandom, $urandom};
        end
        @(negedge i_clk);
        start            <= 1'b1;
        i_mode           <= mode;
        i_slot_index     <= slot;
        i_generation     <= gen;
        i_publish_active <= act;
        i_payload_in     <= pay;
        do @(posedge i_clk); while (busy);
        sb.note_command(mode, slot, gen, act, pay);
    endtask

    // Withdraw start so that the last transaction is not taken again, then drain.
    task automatic wait_for_results();
        int n;
        n = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_results.size() != 0 && n < 1000) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    function automatic int pick_gap(int i);
        int r;
        // Every fourth stretch of sixty transactions runs back to back.
        if ((i / 60) % 4 == 1)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Mostly handles that the table already holds, so that release, publish and query
    // get past the containment check; the rest are stale, zero or out-of-range handles.
    task automatic random_command(input int i);
        int                           pick;
        bit                           wide;
        logic [gst_pkg::MODE_W-1:0]   m;
        logic [gst_pkg::INDEX_W-1:0]  s;
        logic [gst_pkg::GEN_W-1:0]    g;
        wide = (i >= 150 && i < 450);
        pick = $urandom_range(99);
        if (pick < (wide ? 30 : 20))
            m = gst_pkg::MODE_ACTIVATE;
        else if (pick < (wide ? 38 : 30))
            m = gst_pkg::MODE_RELEASE;
        else if (pick < (wide ? 46 : 40))
            m = gst_pkg::MODE_CONTAINS;
        else if (pick < (wide ? 54 : 50))
            m = gst_pkg::MODE_IDENTITY;
        else if (pick < (wide ? 74 : 70))
            m = gst_pkg::MODE_PUBLISH;
        else if (pick < (wide ? 94 : 89))
            m = gst_pkg::MODE_QUERY;
        else if (pick < (wide ? 100 : 97))
            m = gst_pkg::MODE_ISSUE;
        else
            m = gst_pkg::MODE_CLEAR;

        pick = $urandom_range(99);
        if (pick < 5)
            s = gst_pkg::INDEX_W'($urandom);
        else if (pick < (wide ? 85 : 30))
            s = gst_pkg::INDEX_W'($urandom_range(gst_pkg::SLOTS - 1));
        else
            s = gst_pkg::INDEX_W'($urandom_range(15));

        pick = $urandom_range(99);
        if (int'(s) < gst_pkg::SLOTS && sb.gen_of[s[gst_pkg::SLOT_W-1:0]] != 0 && pick < 60)
            g = sb.gen_of[s[gst_pkg::SLOT_W-1:0]];
        else if (pick < 70)
            g = '0;
        else if (pick < 82)
            g = $urandom;
        else
            g = gst_pkg::GEN_W'($urandom_range(1, 4));

        issue_command(m, s, g, 1'($urandom_range(9) != 0), {$urandom, $urandom}, pick_gap(i));
    endtask

    initial begin
        int n;
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_mode           = gst_pkg::MODE_CONTAINS;
        i_slot_index     = '0;
        i_generation     = '0;
        i_publish_active = 1'b0;
        i_payload_in     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue_command(gst_pkg::MODE_CONTAINS, 16'd0, 32'd1, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_ACTIVATE, 16'd3, 32'd0, 1'b1, '1, 0);
        issue_command(gst_pkg::MODE_ACTIVATE, gst_pkg::INDEX_W'(gst_pkg::SLOTS), 32'd1,
                      1'b1, '0, 1);
        issue_command(gst_pkg::MODE_ACTIVATE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '1, 0);
        issue_command(gst_pkg::MODE_ACTIVATE, gst_pkg::INDEX_W'(gst_pkg::SLOTS - 1),
                      32'hFFFF_FFFF, 1'b0, '0, 2);
        issue_command(gst_pkg::MODE_ACTIVATE, 16'd0, 32'd1, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_IDENTITY, gst_pkg::INDEX_W'(gst_pkg::SLOTS - 1), 32'd0,
                      1'b0, '0, 0);
        issue_command(gst_pkg::MODE_IDENTITY, 16'd1, 32'd1, 1'b0, '0, 3);
        issue_command(gst_pkg::MODE_IDENTITY, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '1, 0);
        // An inactive snapshot is refused even for a live handle.
        issue_command(gst_pkg::MODE_PUBLISH, 16'd0, 32'd1, 1'b0, '1, 0);
        issue_command(gst_pkg::MODE_PUBLISH, 16'd0, 32'd1, 1'b1, '1, 0);
        issue_command(gst_pkg::MODE_PUBLISH, gst_pkg::INDEX_W'(gst_pkg::SLOTS - 1),
                      32'hFFFF_FFFF, 1'b1, '0, 1);
        issue_command(gst_pkg::MODE_QUERY, 16'd0, 32'd1, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_QUERY, 16'd0, 32'd2, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_QUERY, 16'd1, 32'd0, 1'b1, '0, 0);
        issue_command(gst_pkg::MODE_PUBLISH, 16'd0, 32'd1, 1'b1, 64'h5555_5555_AAAA_AAAA, 0);
        // Re-activating with the same generation keeps the payload; a new one drops it.
        issue_command(gst_pkg::MODE_ACTIVATE, 16'd0, 32'd1, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_QUERY, 16'd0, 32'd1, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_ACTIVATE, 16'd0, 32'd7, 1'b0, '0, 2);
        issue_command(gst_pkg::MODE_QUERY, 16'd0, 32'd7, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_RELEASE, gst_pkg::INDEX_W'(gst_pkg::SLOTS - 1), 32'd5,
                      1'b0, '0, 0);
        issue_command(gst_pkg::MODE_RELEASE, gst_pkg::INDEX_W'(gst_pkg::SLOTS - 1),
                      32'hFFFF_FFFF, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_RELEASE, 16'd1, 32'd0, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_ISSUE, 16'd0, 32'd0, 1'b0, '0, 0);
        issue_command(gst_pkg::MODE_CLEAR, 16'd0, 32'd0, 1'b0, '0, 1);
        issue_command(gst_pkg::MODE_CONTAINS, 16'd0, 32'd7, 1'b1, '0, 0);
        wait_for_results();

        for (n = 0; n < 650; n++) begin
            if (n == 325)
                wait_for_results();
            random_command(n);
        end
        @(negedge i_clk);
        start <= 1'b0;

        wait_for_results();
        repeat (6) @(posedge i_clk);
        if (sb.pending_results.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0", $time,
                     sb.pending_results.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
